>>> rtl/core/positional_list_engine_defines.svh
// assertion macros used by the checker of the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PLE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list engine: assertion failed");

// consequent must hold in the cycle after the antecedent
`define PLE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list engine: assertion failed");

`endif

>>> rtl/core/ple_pkg.sv
// types and constants of the positional list engine
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 2'd0,
    K_INS_BACK  = 2'd1,
    K_DELETE    = 2'd2,
    K_READ      = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

endpackage

>>> rtl/core/ple_req_if.sv
// request channel of the positional list engine
interface ple_req_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::KIND_W-1:0]          kind;
  logic signed [ple_pkg::VALUE_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]           position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

>>> rtl/core/ple_rsp_if.sv
// result channel of the positional list engine
interface ple_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::STATUS_W-1:0]        status;
  logic signed [ple_pkg::VALUE_W-1:0]  read_value;
  logic [ple_pkg::TOTAL_W-1:0]         element_total;

  modport source (output valid, status, read_value, element_total, input ready);
  modport sink   (input valid, status, read_value, element_total, output ready);
endinterface

>>> rtl/core/ple_ram.sv
// generic single-write, single-read ram with registered read data
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = ple_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/positional_list_engine.sv
// top level of the positional list engine
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in two slot
// memories: one for values and one for next links. Each request inserts at
// the front or back, deletes at a 1-based position, or reads at a 1-based
// position, and gives exactly one result with status, read value and the
// element count. One request is handled at a time. A full list or a bad
// position goes straight to S_DONE, an insert through S_INS; a read walks in
// S_WALK to position p, and a delete walks there and then frees the slot in
// S_DEL, since the position is found by following links from the first
// element one slot per cycle through the registered read port of the link
// memory. S_DONE loads the result into an output register once that register
// is free, so the next request is taken while an earlier result is still
// waiting. Freed slots go to a recycled chain and never-used slots are
// handed out by a high-water count, so no clearing pass runs after reset.
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  ple_req_if.sink   in_req,
  ple_rsp_if.source out_rsp
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W  = ple_pkg::POS_W;
  localparam int unsigned VAL_W  = ple_pkg::VALUE_W;
  localparam int unsigned TOT_W  = ple_pkg::TOTAL_W;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_WALK = 5'b00100,
    S_DEL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  ple_pkg::kind_t           kind_r, kind_nxt;
  logic [VAL_W-1:0]         value_r, value_nxt;
  logic [POS_W-1:0]         rem_r, rem_nxt;
  logic                     pos_first_r, pos_first_nxt;
  logic                     pos_last_r, pos_last_nxt;
  logic [SLOT_W-1:0]        cur_r, cur_nxt;
  logic [SLOT_W-1:0]        prev_r, prev_nxt;
  logic [SLOT_W-1:0]        first_r, first_nxt;
  logic [SLOT_W-1:0]        last_r, last_nxt;
  logic [SLOT_W-1:0]        free_head_r, free_head_nxt;
  logic [CNT_W-1:0]         hwm_r, hwm_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  ple_pkg::status_t         res_status_r, res_status_nxt;
  logic [VAL_W-1:0]         res_value_r, res_value_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [ple_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]         out_value_r, out_value_nxt;
  logic [TOT_W-1:0]         out_total_r, out_total_nxt;

  logic                     in_ready;
  logic                     accept;
  ple_pkg::kind_t           req_kind;
  logic                     req_insert;
  logic                     full;
  logic                     recycled;
  logic                     pos_ok;

  logic                     val_we;
  logic [SLOT_W-1:0]        val_waddr;
  logic [VAL_W-1:0]         val_wdata;
  logic [SLOT_W-1:0]        val_raddr;
  logic [VAL_W-1:0]         val_rdata;
  logic                     link_we;
  logic [SLOT_W-1:0]        link_waddr;
  logic [SLOT_W-1:0]        link_wdata;
  logic [SLOT_W-1:0]        link_raddr;
  logic [SLOT_W-1:0]        link_rdata;

  ple_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  ple_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_req.valid && in_ready;
  assign req_kind   = ple_pkg::kind_t'(in_req.kind);
  assign req_insert = (req_kind == ple_pkg::K_INS_FRONT) || (req_kind == ple_pkg::K_INS_BACK);
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign recycled   = (hwm_r != count_r);
  assign pos_ok     = (in_req.position != '0) &&
                      (CMP_W'(in_req.position) <= CMP_W'(count_r));

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    value_nxt      = value_r;
    rem_nxt        = rem_r;
    pos_first_nxt  = pos_first_r;
    pos_last_nxt   = pos_last_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    free_head_nxt  = free_head_r;
    hwm_nxt        = hwm_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_total_nxt  = out_total_r;

    val_we     = 1'b0;
    val_waddr  = cur_r;
    val_wdata  = value_r;
    val_raddr  = cur_r;
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = free_head_r;
    link_raddr = cur_r;

    unique case (state_r)
      S_IDLE: begin
        val_raddr  = first_r;
        link_raddr = req_insert ? free_head_r : first_r;
        if (accept) begin
          kind_nxt      = req_kind;
          value_nxt     = in_req.value;
          res_value_nxt = '0;
          if (req_insert) begin
            if (full) begin
              res_status_nxt = ple_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              cur_nxt   = recycled ? free_head_r : hwm_r[SLOT_W-1:0];
              state_nxt = S_INS;
            end
          end else if (!pos_ok) begin
            res_status_nxt = ple_pkg::ST_BADPOS;
            state_nxt      = S_DONE;
          end else begin
            rem_nxt       = POS_W'(in_req.position - POS_W'(1));
            pos_first_nxt = (in_req.position == POS_W'(1));
            pos_last_nxt  = (CMP_W'(in_req.position) == CMP_W'(count_r));
            cur_nxt       = first_r;
            state_nxt     = S_WALK;
          end
        end
      end

      S_INS: begin
        val_we = 1'b1;
        if (count_r == '0) begin
          first_nxt = cur_r;
          last_nxt  = cur_r;
        end else if (kind_r == ple_pkg::K_INS_FRONT) begin
          link_we    = 1'b1;
          link_waddr = cur_r;
          link_wdata = first_r;
          first_nxt  = cur_r;
        end else begin
          link_we    = 1'b1;
          link_waddr = last_r;
          link_wdata = cur_r;
          last_nxt   = cur_r;
        end
        if (recycled) begin
          free_head_nxt = link_rdata;
        end else begin
          hwm_nxt = hwm_r + CNT_W'(1);
        end
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = ple_pkg::ST_OK;
        state_nxt      = S_DONE;
      end

      S_WALK: begin
        val_raddr  = link_rdata;
        link_raddr = link_rdata;
        if (rem_r == '0) begin
          if (kind_r == ple_pkg::K_READ) begin
            res_status_nxt = ple_pkg::ST_OK;
            res_value_nxt  = val_rdata;
            state_nxt      = S_DONE;
          end else begin
            if (pos_first_r) begin
              first_nxt = link_rdata;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev_r;
              link_wdata = link_rdata;
              if (pos_last_r) begin
                last_nxt = prev_r;
              end
            end
            state_nxt = S_DEL;
          end
        end else begin
          rem_nxt  = rem_r - POS_W'(1);
          prev_nxt = cur_r;
          cur_nxt  = link_rdata;
        end
      end

      S_DEL: begin
        link_we        = 1'b1;
        link_waddr     = cur_r;
        link_wdata     = free_head_r;
        free_head_nxt  = cur_r;
        count_nxt      = count_r - CNT_W'(1);
        res_status_nxt = ple_pkg::ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_total_nxt  = TOT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      last_r      <= '0;
      free_head_r <= '0;
      hwm_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      free_head_r <= free_head_nxt;
      hwm_r       <= hwm_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    value_r      <= value_nxt;
    rem_r        <= rem_nxt;
    pos_first_r  <= pos_first_nxt;
    pos_last_r   <= pos_last_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign in_req.ready          = in_ready;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.read_value    = out_value_r;
  assign out_rsp.element_total = out_total_r;

endmodule

>>> rtl/core/ple_checker.sv
// port-level checker of the positional list engine and its bind
`include "positional_list_engine_defines.svh"

module ple_checker #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ple_pkg::STATUS_W-1:0]        out_status,
  input logic signed [ple_pkg::VALUE_W-1:0]  out_read_value,
  input logic [ple_pkg::TOTAL_W-1:0]         out_element_total
);

  localparam int unsigned TOT_W = ple_pkg::TOTAL_W;
  localparam logic [TOT_W-1:0] TOTAL_FULL = TOT_W'(CAPACITY);

  // one request in flight at a time
  `PLE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `PLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_read_value) && $stable(out_element_total))

  // only a successful read carries a value
  `PLE_ASSERT_NOW(a_zero_unless_ok, out_valid && (out_status != ple_pkg::ST_OK),
    out_read_value == '0)

  // a full report comes only with the list at capacity
  `PLE_ASSERT_NOW(a_full_total, out_valid && (out_status == ple_pkg::ST_FULL),
    out_element_total == TOTAL_FULL)

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_read_value    (out_rsp.read_value),
  .out_element_total (out_rsp.element_total)
);
